[hw/rtl/bfra_pkg.sv]
// bfra_pkg: shared types and codes for the best-fit range allocator.
// Opcodes, status codes, controller states and the command/status structs.
// No dependencies.
package bfra_pkg;

	localparam int OP_W     = 1;
	localparam int HANDLE_W = 8;
	localparam int CNT_W    = 13;
	localparam int OFF_W    = 12;
	localparam int STAT_W   = 3;

	typedef enum logic [OP_W-1:0] {
		OP_ALLOC = 1'b0,
		OP_FREE  = 1'b1
	} op_t;

	typedef enum logic [STAT_W-1:0] {
		ST_OK         = 3'd0,
		ST_NO_SPACE   = 3'd1,
		ST_IN_USE     = 3'd2,
		ST_NOT_ALLOC  = 3'd3,
		ST_TABLE_FULL = 3'd4
	} status_t;

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_OWN,
		S_SCAN,
		S_DECIDE,
		S_DROP_RD,
		S_DROP_WR,
		S_COMMIT
	} state_t;

	// controller -> datapath
	typedef struct packed {
		logic    clr;
		logic    accept;
		logic    scan_init;
		logic    scan;
		logic    plan;
		logic    drop_rd;
		logic    drop_wr;
		logic    commit;
		logic    finish;
		status_t fin_status;
	} cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic clr_last;
		logic op_free;
		logic own_valid;
		logic cnt_zero;
		logic scan_done;
		logic found;
		logic exact;
		logic has_prev;
		logic has_next;
		logic tbl_full;
		logic more_drops;
	} sts_t;

endpackage

[hw/rtl/bfra_ctrl.sv]
// bfra_ctrl: request sequencer of the best-fit range allocator.
// Drives bfra_dp through cmd_t and reads back sts_t. Depends on bfra_pkg.
module bfra_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	output logic            busy,
	output bfra_pkg::cmd_t  cmd,
	input  bfra_pkg::sts_t  sts
);
	import bfra_pkg::*;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d        = state_q;
		cmd            = '0;
		cmd.fin_status = ST_OK;
		busy           = 1'b1;
		unique case (state_q)
			S_CLEAR: begin
				cmd.clr = 1'b1;
				if (sts.clr_last) state_d = S_IDLE;
			end
			S_IDLE: begin
				busy = 1'b0;
				if (start) begin
					cmd.accept = 1'b1;
					state_d    = S_OWN;
				end
			end
			S_OWN: begin
				if (!sts.op_free && sts.own_valid) begin
					cmd.finish     = 1'b1;
					cmd.fin_status = ST_IN_USE;
					state_d        = S_IDLE;
				end else if (!sts.op_free && sts.cnt_zero) begin
					cmd.finish     = 1'b1;
					cmd.fin_status = ST_NO_SPACE;
					state_d        = S_IDLE;
				end else if (sts.op_free && !sts.own_valid) begin
					cmd.finish     = 1'b1;
					cmd.fin_status = ST_NOT_ALLOC;
					state_d        = S_IDLE;
				end else begin
					cmd.scan_init = 1'b1;
					state_d       = S_SCAN;
				end
			end
			S_SCAN: begin
				cmd.scan = 1'b1;
				if (sts.scan_done) state_d = S_DECIDE;
			end
			S_DECIDE: begin
				if (!sts.op_free && !sts.found) begin
					cmd.finish     = 1'b1;
					cmd.fin_status = ST_NO_SPACE;
					state_d        = S_IDLE;
				end else if (sts.op_free && !sts.has_prev && !sts.has_next && sts.tbl_full) begin
					cmd.finish     = 1'b1;
					cmd.fin_status = ST_TABLE_FULL;
					state_d        = S_IDLE;
				end else begin
					cmd.plan = 1'b1;
					if (sts.op_free ? (sts.has_prev || sts.has_next) : sts.exact) begin
						state_d = S_DROP_RD;
					end else begin
						state_d = S_COMMIT;
					end
				end
			end
			S_DROP_RD: begin
				cmd.drop_rd = 1'b1;
				state_d     = S_DROP_WR;
			end
			S_DROP_WR: begin
				cmd.drop_wr = 1'b1;
				state_d     = sts.more_drops ? S_DROP_RD : S_COMMIT;
			end
			S_COMMIT: begin
				cmd.commit     = 1'b1;
				cmd.finish     = 1'b1;
				cmd.fin_status = ST_OK;
				state_d        = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

endmodule

[hw/rtl/bfra_dp.sv]
// bfra_dp: datapath of the best-fit range allocator.
// Holds the free range table, the owner table, the scan and merge registers
// and the result register. Depends on bfra_pkg; sequenced by bfra_ctrl.
module bfra_dp #(
	parameter int STORE_SLOTS      = 4096,
	parameter int FREE_TABLE_DEPTH = 64,
	parameter int HANDLE_COUNT     = 256
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic [bfra_pkg::OP_W-1:0]       opcode,
	input  logic [bfra_pkg::HANDLE_W-1:0]   handle,
	input  logic [bfra_pkg::CNT_W-1:0]      count,
	input  bfra_pkg::cmd_t                  cmd,
	output bfra_pkg::sts_t                  sts,
	output logic                            done,
	output logic [bfra_pkg::STAT_W-1:0]     status,
	output logic [bfra_pkg::OFF_W-1:0]      offset,
	output logic [bfra_pkg::CNT_W-1:0]      size
);
	import bfra_pkg::*;

	localparam int SW  = $clog2(STORE_SLOTS);
	localparam int LW  = $clog2(STORE_SLOTS + 1);
	localparam int CW  = (LW > CNT_W) ? LW : CNT_W;
	localparam int XW  = CW + 1;
	localparam int FW  = $clog2(FREE_TABLE_DEPTH);
	localparam int FCW = $clog2(FREE_TABLE_DEPTH + 1);
	localparam int HW  = $clog2(HANDLE_COUNT);

	typedef struct packed {
		logic [SW-1:0] start;
		logic [LW-1:0] len;
	} free_ent_t;

	typedef struct packed {
		logic             valid;
		logic [SW-1:0]    start;
		logic [CNT_W-1:0] len;
	} own_ent_t;

	free_ent_t free_mem [FREE_TABLE_DEPTH];
	own_ent_t  own_mem  [HANDLE_COUNT];

	// handle reduced modulo the handle count
	logic [HW-1:0] hmod;
	if (HANDLE_COUNT >= 256) begin : g_hdirect
		assign hmod = HW'(handle);
	end else begin : g_hmod
		logic [HW-1:0] hmod_tab [256];
		for (genvar gi = 0; gi < 256; gi++) begin : g_tab
			assign hmod_tab[gi] = HW'(gi % HANDLE_COUNT);
		end
		assign hmod = hmod_tab[handle];
	end

	// request registers
	op_t              op_q;
	logic [HW-1:0]    h_q;
	logic [CNT_W-1:0] cnt_q;
	own_ent_t         own_q;

	// control registers
	logic [FCW-1:0] n_q;
	logic [HW-1:0]  clr_idx_q;
	logic [FCW-1:0] scan_idx_q;
	logic           rv_s1;
	logic           found_q, prev_q, next_q;
	logic [1:0]     drops_q;
	logic           done_q;

	// payload registers
	logic [FW-1:0]     ridx_s1;
	free_ent_t         free_rd_q;
	logic [FW-1:0]     best_idx_q, p_idx_q, n_idx_q, tgt_a_q, tgt_b_q;
	logic [SW-1:0]     best_start_q, p_start_q, new_start_q;
	logic [LW-1:0]     best_len_q, p_len_q, nx_len_q, new_len_q;
	logic [STAT_W-1:0] status_q;
	logic [OFF_W-1:0]  offset_q;
	logic [CNT_W-1:0]  size_q;

	// scan compare
	logic          fits, better, is_prev, is_next, exact, issue;
	logic          take_best, take_prev, take_next;
	logic [XW-1:0] e_end, o_end;
	logic [FW-1:0] rd_addr;
	logic [FCW-1:0] n_dec;

	assign issue   = cmd.scan && (scan_idx_q < n_q);
	assign n_dec   = n_q - FCW'(1);
	assign rd_addr = cmd.drop_rd ? n_dec[FW-1:0] : scan_idx_q[FW-1:0];
	assign fits    = CW'(free_rd_q.len) >= CW'(cnt_q);
	assign better  = !found_q || (free_rd_q.len < best_len_q) ||
			((free_rd_q.len == best_len_q) && (free_rd_q.start < best_start_q));
	assign e_end   = XW'(free_rd_q.start) + XW'(free_rd_q.len);
	assign o_end   = XW'(own_q.start) + XW'(own_q.len);
	assign is_prev = e_end == XW'(own_q.start);
	assign is_next = XW'(free_rd_q.start) == o_end;
	assign exact   = CW'(best_len_q) == CW'(cnt_q);

	assign take_best = rv_s1 && (op_q == OP_ALLOC) && fits && better;
	assign take_prev = rv_s1 && (op_q == OP_FREE) && !prev_q && is_prev;
	assign take_next = rv_s1 && (op_q == OP_FREE) && !take_prev && !next_q && is_next;

	// free table write port
	logic          fw_en;
	logic [FW-1:0] fw_addr;
	free_ent_t     fw_data;
	own_ent_t      ow_data;

	always_comb begin
		fw_en   = 1'b0;
		fw_addr = tgt_a_q;
		fw_data = free_rd_q;
		if (cmd.clr) begin
			fw_en         = 1'b1;
			fw_addr       = '0;
			fw_data.start = '0;
			fw_data.len   = LW'(STORE_SLOTS);
		end else if (cmd.drop_wr) begin
			fw_en = 1'b1;
		end else if (cmd.commit) begin
			if (op_q == OP_FREE) begin
				fw_en         = 1'b1;
				fw_addr       = n_q[FW-1:0];
				fw_data.start = new_start_q;
				fw_data.len   = new_len_q;
			end else if (!exact) begin
				// best range shrinks to the remainder
				fw_en         = 1'b1;
				fw_addr       = best_idx_q;
				fw_data.start = best_start_q + SW'(cnt_q);
				fw_data.len   = best_len_q - LW'(cnt_q);
			end
		end
	end

	always_comb begin
		if (op_q == OP_ALLOC) begin
			ow_data.valid = 1'b1;
			ow_data.start = best_start_q;
			ow_data.len   = cnt_q;
		end else begin
			ow_data       = own_q;
			ow_data.valid = 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fw_en) free_mem[fw_addr] <= fw_data;
		free_rd_q <= free_mem[rd_addr];
	end

	always_ff @(posedge clk) begin
		if (cmd.clr) begin
			own_mem[clr_idx_q] <= '0;
		end else if (cmd.commit) begin
			own_mem[h_q] <= ow_data;
		end
		if (cmd.accept) own_q <= own_mem[hmod];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			n_q        <= FCW'(1);
			clr_idx_q  <= '0;
			scan_idx_q <= '0;
			rv_s1      <= 1'b0;
			found_q    <= 1'b0;
			prev_q     <= 1'b0;
			next_q     <= 1'b0;
			drops_q    <= '0;
			done_q     <= 1'b0;
		end else begin
			done_q <= cmd.finish;
			rv_s1  <= issue;
			if (cmd.clr) clr_idx_q <= clr_idx_q + HW'(1);
			if (cmd.scan_init) begin
				scan_idx_q <= '0;
				found_q    <= 1'b0;
				prev_q     <= 1'b0;
				next_q     <= 1'b0;
			end else begin
				if (issue) scan_idx_q <= scan_idx_q + FCW'(1);
				if (take_best) found_q <= 1'b1;
				if (take_prev) prev_q <= 1'b1;
				if (take_next) next_q <= 1'b1;
			end
			if (cmd.plan) begin
				if (op_q == OP_ALLOC) begin
					drops_q <= exact ? 2'd1 : 2'd0;
				end else begin
					drops_q <= 2'(prev_q) + 2'(next_q);
				end
			end else if (cmd.drop_wr) begin
				drops_q <= drops_q - 2'd1;
			end
			if (cmd.drop_rd) begin
				n_q <= n_dec;
			end else if (cmd.commit && (op_q == OP_FREE)) begin
				n_q <= n_q + FCW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			op_q  <= op_t'(opcode);
			h_q   <= hmod;
			cnt_q <= count;
		end
		ridx_s1 <= scan_idx_q[FW-1:0];
		if (take_best) begin
			best_idx_q   <= ridx_s1;
			best_start_q <= free_rd_q.start;
			best_len_q   <= free_rd_q.len;
		end
		if (take_prev) begin
			p_idx_q   <= ridx_s1;
			p_start_q <= free_rd_q.start;
			p_len_q   <= free_rd_q.len;
		end
		if (take_next) begin
			n_idx_q  <= ridx_s1;
			nx_len_q <= free_rd_q.len;
		end
		if (cmd.plan) begin
			// with two neighbours the higher index is dropped first
			if (op_q == OP_ALLOC) begin
				tgt_a_q <= best_idx_q;
			end else if (prev_q && next_q) begin
				tgt_a_q <= (p_idx_q > n_idx_q) ? p_idx_q : n_idx_q;
				tgt_b_q <= (p_idx_q > n_idx_q) ? n_idx_q : p_idx_q;
			end else begin
				tgt_a_q <= prev_q ? p_idx_q : n_idx_q;
			end
			new_start_q <= prev_q ? p_start_q : own_q.start;
			new_len_q   <= LW'(own_q.len) + (prev_q ? p_len_q : LW'(0)) +
					(next_q ? nx_len_q : LW'(0));
		end else if (cmd.drop_wr) begin
			tgt_a_q <= tgt_b_q;
		end
		if (cmd.finish) begin
			status_q <= cmd.fin_status;
			if (cmd.fin_status == ST_OK) begin
				offset_q <= OFF_W'((op_q == OP_ALLOC) ? best_start_q : own_q.start);
				size_q   <= (op_q == OP_ALLOC) ? cnt_q : own_q.len;
			end else begin
				offset_q <= '0;
				size_q   <= '0;
			end
		end
	end

	always_comb begin
		sts.clr_last   = clr_idx_q == HW'(HANDLE_COUNT - 1);
		sts.op_free    = op_q == OP_FREE;
		sts.own_valid  = own_q.valid;
		sts.cnt_zero   = cnt_q == '0;
		sts.scan_done  = (scan_idx_q == n_q) && !rv_s1;
		sts.found      = found_q;
		sts.exact      = exact;
		sts.has_prev   = prev_q;
		sts.has_next   = next_q;
		sts.tbl_full   = n_q >= FCW'(FREE_TABLE_DEPTH);
		sts.more_drops = drops_q == 2'd2;
	end

	assign done   = done_q;
	assign status = status_q;
	assign offset = offset_q;
	assign size   = size_q;

	a_drop_pending: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.drop_wr |-> (drops_q != 2'd0))
		else $error("range drop with no drop pending");

	a_append_room: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.commit && (op_q == OP_FREE)) |-> (n_q < FCW'(FREE_TABLE_DEPTH)))
		else $error("append to a full range table");

	a_scan_in_table: assert property (@(posedge clk) disable iff (!arst_n)
		rv_s1 |-> (FCW'(ridx_s1) < n_q))
		else $error("scan read beyond the valid ranges");

	a_alloc_fits: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.commit && (op_q == OP_ALLOC)) |-> (found_q && (CW'(best_len_q) >= CW'(cnt_q))))
		else $error("allocate committed without a fitting range");

endmodule

[hw/rtl/best_fit_range_allocator_unit.sv]
// Best-fit range allocator, top level: controller plus datapath.
// Depends on bfra_pkg, bfra_ctrl and bfra_dp.
//
// A request is taken when start is high and busy is low. Its single result
// appears on status/offset/size for one cycle with done high, and must be
// captured then, as the block cannot be held off. Every request reads the
// owner table once. A request that passes the handle and count checks then
// walks the free range table one entry a cycle through its single read port.
// After the walk, ranges are removed from the table before the result: one
// on an exact-fit allocate, one or two on a free that merges with its
// neighbours. No space and table full are known once the walk ends and are
// answered before any range is removed. Handle misuse and a zero count are
// answered from the owner table read, without a walk. After reset the block
// runs a clearing pass over the owner table, one handle per cycle, and holds
// busy high until every handle has been cleared.
module best_fit_range_allocator_unit #(
	parameter int STORE_SLOTS      = 4096,
	parameter int FREE_TABLE_DEPTH = 64,
	parameter int HANDLE_COUNT     = 256
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	output logic                            busy,
	input  logic [bfra_pkg::OP_W-1:0]       opcode,
	input  logic [bfra_pkg::HANDLE_W-1:0]   handle,
	input  logic [bfra_pkg::CNT_W-1:0]      count,
	output logic                            done,
	output logic [bfra_pkg::STAT_W-1:0]     status,
	output logic [bfra_pkg::OFF_W-1:0]      offset,
	output logic [bfra_pkg::CNT_W-1:0]      size
);
	import bfra_pkg::*;

	cmd_t cmd;
	sts_t sts;

	bfra_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.cmd    (cmd),
		.sts    (sts)
	);

	bfra_dp #(
		.STORE_SLOTS      (STORE_SLOTS),
		.FREE_TABLE_DEPTH (FREE_TABLE_DEPTH),
		.HANDLE_COUNT     (HANDLE_COUNT)
	) u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.opcode (opcode),
		.handle (handle),
		.count  (count),
		.cmd    (cmd),
		.sts    (sts),
		.done   (done),
		.status (status),
		.offset (offset),
		.size   (size)
	);

endmodule
